// File: hw/rtl/mm3_pkg.sv
// Shared types, constants and helpers for the streaming MurmurHash3 x86_32 block.
package mm3_pkg;

    localparam int WORD_W = 32;
    localparam int CNT_W  = 3;

    localparam logic [CNT_W-1:0] FULL_BYTES = 3'd4;

    localparam logic [WORD_W-1:0] MIX_C1  = 32'hcc9e2d51;
    localparam logic [WORD_W-1:0] MIX_C2  = 32'h1b873593;
    localparam logic [WORD_W-1:0] MIX_N   = 32'he6546b64;
    localparam logic [WORD_W-1:0] FIN_F1  = 32'h85ebca6b;
    localparam logic [WORD_W-1:0] FIN_F2  = 32'hc2b2ae35;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRE1,
        ST_PRE2,
        ST_MIX,
        ST_FIN0,
        ST_FIN1,
        ST_FIN2,
        ST_FIN3
    } mm3_state_t;

    typedef struct packed {
        logic load;
        logic pre1;
        logic pre2;
        logic mix;
        logic fin0;
        logic fin1;
        logic fin2;
        logic fin3;
    } mm3_cmd_t;

    typedef struct packed {
        logic last;
        logic out_free;
    } mm3_status_t;

    function automatic logic [WORD_W-1:0] byte_mask(input logic [CNT_W-1:0] cnt);
        logic [WORD_W-1:0] m;
        begin
            case (cnt)
                3'd0:    m = 32'h0000_0000;
                3'd1:    m = 32'h0000_00ff;
                3'd2:    m = 32'h0000_ffff;
                3'd3:    m = 32'h00ff_ffff;
                default: m = 32'hffff_ffff;
            endcase
            return m;
        end
    endfunction

endpackage

// File: hw/rtl/mm3_in_if.sv
// Input item channel: key word, byte count, first/last flags and seed.
interface mm3_in_if
    import mm3_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] key_word;
    logic [CNT_W-1:0]  valid_bytes;
    logic              first_word;
    logic              last_word;
    logic [WORD_W-1:0] seed_value;

    modport source (
        output valid, key_word, valid_bytes, first_word, last_word, seed_value,
        input  ready
    );
    modport sink (
        input  valid, key_word, valid_bytes, first_word, last_word, seed_value,
        output ready
    );
endinterface

// File: hw/rtl/mm3_out_if.sv
// Result item channel: finalized 32-bit hash.
interface mm3_out_if
    import mm3_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] hash_value;

    modport source (
        output valid, hash_value,
        input  ready
    );
    modport sink (
        input  valid, hash_value,
        output ready
    );
endinterface

// File: hw/rtl/mm3_ctrl.sv
// Sequencing state machine: premix, body/tail mix and finalization steps.
module mm3_ctrl
    import mm3_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  mm3_status_t status,
    output logic        in_ready,
    output mm3_cmd_t    cmd
);

    mm3_state_t state_reg;
    mm3_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_PRE1;
                end
            end
            ST_PRE1: state_next = ST_PRE2;
            ST_PRE2: state_next = ST_MIX;
            ST_MIX:  state_next = status.last ? ST_FIN0 : ST_IDLE;
            ST_FIN0: state_next = ST_FIN1;
            ST_FIN1: state_next = ST_FIN2;
            ST_FIN2: state_next = ST_FIN3;
            ST_FIN3:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_PRE1: cmd.pre1 = 1'b1;
            ST_PRE2: cmd.pre2 = 1'b1;
            ST_MIX:  cmd.mix  = 1'b1;
            ST_FIN0: cmd.fin0 = 1'b1;
            ST_FIN1: cmd.fin1 = 1'b1;
            ST_FIN2: cmd.fin2 = 1'b1;
            ST_FIN3: cmd.fin3 = status.out_free;
            default: cmd      = '0;
        endcase
    end

    a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == ST_PRE1)
        else $error("accepted item did not start premix");

    a_fin_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN3 && !status.out_free) |=> state_reg == ST_FIN3)
        else $error("final step left while result slot busy");

    a_mix_returns: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MIX && !status.last) |=> state_reg == ST_IDLE)
        else $error("non-last item did not return to idle after mix");

endmodule

// File: hw/rtl/mm3_dpath.sv
// Hash datapath: item registers, premix multiplies, running hash, length, avalanche.
module mm3_dpath
    import mm3_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  mm3_cmd_t          cmd,
    input  logic [WORD_W-1:0] key_word,
    input  logic [CNT_W-1:0]  valid_bytes,
    input  logic              first_word,
    input  logic              last_word,
    input  logic [WORD_W-1:0] seed_value,
    input  logic              out_ready,
    output mm3_status_t       status,
    output logic              out_valid,
    output logic [WORD_W-1:0] hash_value
);

    logic [WORD_W-1:0] word_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              first_reg;
    logic              last_reg;
    logic [WORD_W-1:0] seed_reg;
    logic [WORD_W-1:0] k_reg;
    logic [WORD_W-1:0] hash_reg;
    logic [WORD_W-1:0] len_reg;
    logic [WORD_W-1:0] fin_reg;
    logic [WORD_W-1:0] out_hash_reg;
    logic              out_valid_reg;

    logic [CNT_W-1:0]  cnt_sat;
    logic [WORD_W-1:0] k_rot;
    logic [WORD_W-1:0] h_base;
    logic [WORD_W-1:0] h_xor;
    logic [WORD_W-1:0] h_rot;
    logic [WORD_W-1:0] h_next;
    logic [WORD_W-1:0] len_next;
    logic [WORD_W-1:0] f_init;
    logic [WORD_W-1:0] f_mid;
    logic [WORD_W-1:0] f_out;

    always_comb
    begin
        cnt_sat  = (valid_bytes > FULL_BYTES) ? FULL_BYTES : valid_bytes;
        k_rot    = {k_reg[16:0], k_reg[31:17]};
        h_base   = first_reg ? seed_reg : hash_reg;
        h_xor    = h_base ^ k_reg;
        h_rot    = {h_xor[18:0], h_xor[31:19]};
        h_next   = (cnt_reg == FULL_BYTES) ? (h_rot + {h_rot[29:0], 2'b00} + MIX_N) : h_xor;
        len_next = (first_reg ? '0 : len_reg) + {{(WORD_W-CNT_W){1'b0}}, cnt_reg};
        f_init   = hash_reg ^ len_reg;
        f_mid    = fin_reg ^ {13'd0, fin_reg[31:13]};
        f_out    = fin_reg ^ {16'd0, fin_reg[31:16]};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            word_reg  <= key_word & byte_mask(cnt_sat);
            cnt_reg   <= cnt_sat;
            first_reg <= first_word;
            last_reg  <= last_word;
            seed_reg  <= seed_value;
        end
        if (cmd.pre1)
        begin
            k_reg <= word_reg * MIX_C1;
        end
        else if (cmd.pre2)
        begin
            k_reg <= k_rot * MIX_C2;
        end
        if (cmd.fin0)
        begin
            fin_reg <= f_init ^ {16'd0, f_init[31:16]};
        end
        else if (cmd.fin1)
        begin
            fin_reg <= fin_reg * FIN_F1;
        end
        else if (cmd.fin2)
        begin
            fin_reg <= f_mid * FIN_F2;
        end
        if (cmd.fin3)
        begin
            out_hash_reg <= f_out;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg      <= '0;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.mix)
            begin
                hash_reg <= h_next;
                len_reg  <= len_next;
            end
            else if (cmd.fin0)
            begin
                hash_reg <= '0;
                len_reg  <= '0;
            end
            if (cmd.fin3)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.last     = last_reg;
    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign hash_value      = out_hash_reg;

    a_fin_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fin0 |=> (hash_reg == '0 && len_reg == '0))
        else $error("running state not cleared after last item");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> cnt_reg <= FULL_BYTES)
        else $error("byte count above four");

    a_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fin3 |-> (!out_valid_reg || out_ready))
        else $error("result written over a pending result");

endmodule

// File: hw/rtl/murmur3_32_hash_stream.sv
// Top level of the streaming MurmurHash3 x86_32 block.
// Keys stream in one 32-bit little-endian word per item; an item with first_word set loads
// seed_value, and the item with last_word set yields one hash_value on the result channel.
// Each item occupies the shared datapath for load, two premix multiplies and mix; an item
// with last_word then runs the finalization steps, and the next item is taken only after
// those steps. in_ch.ready is high only between items. The result sits in an output
// register, so a new key is taken while the previous hash waits; a later hash waits in its
// last finalization step until that register is free.
module murmur3_32_hash_stream
    import mm3_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    mm3_in_if.sink    in_ch,
    mm3_out_if.source out_ch
);

    mm3_cmd_t    cmd;
    mm3_status_t status;
    logic        in_ready;

    mm3_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .status   (status),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    mm3_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .key_word    (in_ch.key_word),
        .valid_bytes (in_ch.valid_bytes),
        .first_word  (in_ch.first_word),
        .last_word   (in_ch.last_word),
        .seed_value  (in_ch.seed_value),
        .out_ready   (out_ch.ready),
        .status      (status),
        .out_valid   (out_ch.valid),
        .hash_value  (out_ch.hash_value)
    );

    assign in_ch.ready = in_ready;

endmodule
